// ----- sv/arfg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_pkg
// Types, constants and byte tables shared by the auto-reply frame generator.
// ----------------------------------------------------------------------------
package arfg_pkg;

  localparam int RECORD_BYTES     = 41;
  localparam int VOICE_FRAMES_DEF = 11;
  localparam int FIXED_BYTES      = 6;
  localparam int HDR_BYTES        = FIXED_BYTES + RECORD_BYTES;
  localparam int FRM_BYTES        = 18;
  localparam int VOICE_BYTES      = FRM_BYTES - FIXED_BYTES;
  localparam int MEM_DEPTH        = 2 * RECORD_BYTES;
  localparam int MEM_AW           = $clog2(MEM_DEPTH);
  localparam int CNT_W            = $clog2(HDR_BYTES);
  localparam int SEQ_W            = 5;
  localparam int ELAPSED_W        = 17;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int FIFO_DEPTH       = 2;
  localparam int TEXT_W           = 160;

  localparam logic [15:0] WAIT_RESET = 16'd1000;

  // fixed packet bytes
  localparam logic [7:0] HDR_B0     = 8'h2f;
  localparam logic [7:0] HDR_B1     = 8'ha0;
  localparam logic [7:0] HDR_B4     = 8'h80;
  localparam logic [7:0] HDR_B5     = 8'h00;
  localparam logic [7:0] FRM_B0     = 8'h12;
  localparam logic [7:0] FRM_B1     = 8'hc0;
  localparam logic [7:0] LAST_FLAG  = 8'h40;
  localparam logic [7:0] BUSY_MASK  = 8'h07;
  localparam logic [7:0] NORESP_B0  = 8'h02;
  localparam logic [7:0] MINI_HDR   = 8'h40;
  localparam logic [7:0] SCR_A      = 8'h70;
  localparam logic [7:0] SCR_B      = 8'h4f;
  localparam logic [7:0] SCR_C      = 8'h93;
  localparam int         TEXT_SEQS  = 8;

  localparam logic [95:0] SYNC_VOICE = 96'h9e8d3288261a3f61e8552d16;
  localparam logic [95:0] FILL_VOICE = 96'h9e8d3288261a3f61e81629f5;
  localparam logic [TEXT_W-1:0] TEXT_BUSY   = "Dest. Busy          ";
  localparam logic [TEXT_W-1:0] TEXT_NORESP = "No Response         ";

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_START = 2'd1,
    OP_SKIP  = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PK_HEADER = 2'd0,
    PK_VOICE  = 2'd1,
    PK_LAST   = 2'd2
  } pkt_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 1'd0,
    CFG_WAIT   = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_BUSY   = 2'd1,
    REPLY_NORESP = 2'd2
  } reply_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT_SET, PH_WAIT_CHECK, PH_HEADER, PH_HEADER_DONE,
    PH_TEXT_SET, PH_VOICE_PREP, PH_VOICE, PH_LAST_PREP, PH_LAST, PH_END
  } phase_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic        time_tick;
    logic        squelch_open;
    logic        reply_kind;
    logic [15:0] session_id;
    logic        record_select;
    logic [5:0]  record_index;
    logic [7:0]  record_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] packet_kind;
    logic       last_of_packet;
  } out_item_t;

  typedef struct packed {
    pkt_kind_e        kind;
    logic             no_resp;
    logic [15:0]      sid;
    logic [7:0]       fbyte;
    logic [SEQ_W-1:0] seq;
    logic [7:0]       pcnt;
  } pkt_cmd_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } rec_wr_t;

  function automatic logic [7:0] text_char(logic no_resp, logic [4:0] pos);
    logic [TEXT_W-1:0] t;
    t = no_resp ? TEXT_NORESP : TEXT_BUSY;
    return t[TEXT_W - 1 - 8 * int'(pos) -: 8];
  endfunction

  // Data byte j (0..11) of voice frame seq.
  function automatic logic [7:0] voice_byte(logic [SEQ_W-1:0] seq, logic no_resp,
                                            logic [3:0] j);
    logic [4:0] half;
    logic [4:0] base;
    logic [7:0] b9;
    logic [7:0] b10;
    logic [7:0] b11;
    logic [7:0] res;
    half = '0;
    base = '0;
    b9   = '0;
    b10  = '0;
    b11  = '0;
    if (seq == '0) begin
      res = SYNC_VOICE[95 - 8 * int'(j) -: 8];
    end else if (seq > SEQ_W'(TEXT_SEQS) || j < 4'(VOICE_BYTES - 3)) begin
      res = FILL_VOICE[95 - 8 * int'(j) -: 8];
    end else begin
      if (seq[0]) begin
        half = 5'((seq - 1'b1) >> 1);
        base = 5'(half * 5);
        b9   = (MINI_HDR + 8'(half)) ^ SCR_A;
        b10  = text_char(no_resp, base) ^ SCR_B;
        b11  = text_char(no_resp, 5'(base + 5'd1)) ^ SCR_C;
      end else begin
        half = 5'((seq >> 1) - 1'b1);
        base = 5'(half * 5 + 2);
        b9   = text_char(no_resp, base) ^ SCR_A;
        b10  = text_char(no_resp, 5'(base + 5'd1)) ^ SCR_B;
        b11  = text_char(no_resp, 5'(base + 5'd2)) ^ SCR_C;
      end
      if (j == 4'(VOICE_BYTES - 3)) begin
        res = b9;
      end else if (j == 4'(VOICE_BYTES - 2)) begin
        res = b10;
      end else begin
        res = b11;
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/arfg_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_in_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface arfg_in_if;
  logic               valid;
  logic               ready;
  arfg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/arfg_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_out_if
// Valid/ready channel carrying one emitted packet byte.
// ----------------------------------------------------------------------------
interface arfg_out_if;
  logic                valid;
  logic                ready;
  arfg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/arfg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_front
// Accepts items, runs the reply phase sequencer and issues packet commands.
// ----------------------------------------------------------------------------
module arfg_front #(
  parameter int VOICE_FRAMES = arfg_pkg::VOICE_FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  arfg_in_if.sink                         in_ch,
  input  logic                            cfg_we_i,
  input  logic [arfg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            back_idle_i,
  input  logic                            cmd_ready_i,
  output logic                            cmd_valid_o,
  output arfg_pkg::pkt_cmd_t              cmd_o,
  output arfg_pkg::rec_wr_t               rec_wr_o
);

  localparam int FrameW = $clog2(VOICE_FRAMES + 1);

  arfg_pkg::phase_e                 phase_q, phase_d;
  arfg_pkg::reply_e                 pending_q, pending_d;
  logic [arfg_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d, elapsed_inc;
  logic [FrameW-1:0]                frame_q, frame_d, frame_inc;
  logic [7:0]                       pcnt_q, pcnt_d, pcnt_inc;
  logic [15:0]                      sid_q, sid_d;
  logic                             enable_q;
  logic [15:0]                      wait_q;

  arfg_pkg::in_item_t item;
  arfg_pkg::op_e      op;
  logic               acc;
  logic               poll_act;

  assign item = in_ch.data;
  assign op   = arfg_pkg::op_e'(item.operation);

  // hold loads until the back end has read all record bytes it was given
  assign in_ch.ready = cmd_ready_i && (op != arfg_pkg::OP_LOAD || back_idle_i);
  assign acc         = in_ch.valid && in_ch.ready;
  assign poll_act    = acc && op == arfg_pkg::OP_POLL && enable_q &&
                       pending_q != arfg_pkg::REPLY_NONE;

  assign frame_inc = frame_q + 1'b1;
  assign pcnt_inc  = pcnt_q + 8'd1;

  always_comb begin
    elapsed_inc = elapsed_q;
    if (phase_q == arfg_pkg::PH_WAIT_CHECK && item.time_tick && elapsed_q != '1) begin
      elapsed_inc = elapsed_q + 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    elapsed_d = elapsed_q;
    frame_d   = frame_q;
    pcnt_d    = pcnt_q;
    sid_d     = sid_q;
    if (acc) begin
      elapsed_d = elapsed_inc;
      unique case (op)
        arfg_pkg::OP_START: begin
          if (phase_q == arfg_pkg::PH_IDLE) begin
            pending_d = item.reply_kind ? arfg_pkg::REPLY_NORESP : arfg_pkg::REPLY_BUSY;
            phase_d   = arfg_pkg::PH_WAIT_SET;
          end
        end
        arfg_pkg::OP_SKIP: begin
          phase_d   = arfg_pkg::PH_IDLE;
          pending_d = arfg_pkg::REPLY_NONE;
        end
        arfg_pkg::OP_LOAD: begin
        end
        arfg_pkg::OP_POLL: begin
          if (enable_q) begin
            if (pending_q == arfg_pkg::REPLY_NONE) begin
              phase_d = arfg_pkg::PH_IDLE;
            end else begin
              unique case (phase_q)
                arfg_pkg::PH_WAIT_SET: begin
                  if (!item.squelch_open) begin
                    elapsed_d = '0;
                    frame_d   = '0;
                    phase_d   = arfg_pkg::PH_WAIT_CHECK;
                  end
                end
                arfg_pkg::PH_WAIT_CHECK: begin
                  if (!item.squelch_open &&
                      elapsed_inc > arfg_pkg::ELAPSED_W'(wait_q)) begin
                    phase_d = arfg_pkg::PH_HEADER;
                  end
                end
                arfg_pkg::PH_HEADER: begin
                  sid_d   = item.session_id;
                  pcnt_d  = '0;
                  phase_d = arfg_pkg::PH_HEADER_DONE;
                end
                arfg_pkg::PH_HEADER_DONE: phase_d = arfg_pkg::PH_TEXT_SET;
                arfg_pkg::PH_TEXT_SET:    phase_d = arfg_pkg::PH_VOICE_PREP;
                arfg_pkg::PH_VOICE_PREP:  phase_d = arfg_pkg::PH_VOICE;
                arfg_pkg::PH_VOICE: begin
                  pcnt_d  = pcnt_inc;
                  frame_d = frame_inc;
                  if (frame_inc >= FrameW'(VOICE_FRAMES)) begin
                    phase_d = arfg_pkg::PH_LAST_PREP;
                  end
                end
                arfg_pkg::PH_LAST_PREP: phase_d = arfg_pkg::PH_LAST;
                arfg_pkg::PH_LAST: begin
                  pcnt_d  = pcnt_inc;
                  phase_d = arfg_pkg::PH_END;
                end
                arfg_pkg::PH_END: begin
                  phase_d   = arfg_pkg::PH_IDLE;
                  pending_d = arfg_pkg::REPLY_NONE;
                end
                arfg_pkg::PH_IDLE: begin
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command issue
  always_comb begin
    cmd_valid_o   = 1'b0;
    cmd_o.kind    = arfg_pkg::PK_HEADER;
    cmd_o.no_resp = pending_q == arfg_pkg::REPLY_NORESP;
    cmd_o.sid     = sid_q;
    cmd_o.fbyte   = 8'(frame_q);
    cmd_o.seq     = arfg_pkg::SEQ_W'(frame_q);
    cmd_o.pcnt    = pcnt_inc;
    if (poll_act) begin
      unique case (phase_q)
        arfg_pkg::PH_HEADER: begin
          cmd_valid_o = 1'b1;
          cmd_o.sid   = item.session_id;
          cmd_o.pcnt  = '0;
        end
        arfg_pkg::PH_VOICE: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = arfg_pkg::PK_VOICE;
        end
        arfg_pkg::PH_LAST: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = arfg_pkg::PK_LAST;
          cmd_o.fbyte = 8'(frame_q) | arfg_pkg::LAST_FLAG;
          cmd_o.seq   = (frame_q != '0) ? arfg_pkg::SEQ_W'(frame_q - 1'b1) : '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rec_wr_o.we   = acc && op == arfg_pkg::OP_LOAD &&
                    item.record_index < 6'(arfg_pkg::RECORD_BYTES);
    rec_wr_o.addr = item.record_select ?
                    arfg_pkg::MEM_AW'(arfg_pkg::RECORD_BYTES) +
                    arfg_pkg::MEM_AW'(item.record_index) :
                    arfg_pkg::MEM_AW'(item.record_index);
    rec_wr_o.data = item.record_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= arfg_pkg::PH_IDLE;
      pending_q <= arfg_pkg::REPLY_NONE;
      elapsed_q <= '0;
      frame_q   <= '0;
      pcnt_q    <= '0;
      sid_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      elapsed_q <= elapsed_d;
      frame_q   <= frame_d;
      pcnt_q    <= pcnt_d;
      sid_q     <= sid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      wait_q   <= arfg_pkg::WAIT_RESET;
    end else if (cfg_we_i) begin
      unique case (arfg_pkg::cfg_idx_e'(cfg_idx_i))
        arfg_pkg::CFG_ENABLE: enable_q <= cfg_data_i[0];
        arfg_pkg::CFG_WAIT:   wait_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/arfg_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_cmd_fifo
// Short queue of packet commands between the sequencer and the byte emitter.
// ----------------------------------------------------------------------------
module arfg_cmd_fifo #(
  parameter int DEPTH = arfg_pkg::FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  arfg_pkg::pkt_cmd_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output arfg_pkg::pkt_cmd_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  arfg_pkg::pkt_cmd_t entries_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               push, pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/arfg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_back
// Expands packet commands into bytes, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module arfg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arfg_pkg::rec_wr_t  rec_wr_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  arfg_pkg::pkt_cmd_t cmd_i,
  output logic               idle_o,
  arfg_out_if.source         out_ch
);

  logic [7:0] mem_q [arfg_pkg::MEM_DEPTH];

  logic                           act_q;
  arfg_pkg::pkt_cmd_t             cmd_q;
  logic [arfg_pkg::CNT_W-1:0]     cnt_q;
  logic                           s1_valid_q;
  arfg_pkg::pkt_cmd_t             s1_cmd_q;
  logic [arfg_pkg::CNT_W-1:0]     s1_cnt_q;
  logic                           s1_last_q;
  logic [7:0]                     rd_q;
  logic                           out_valid_q;
  arfg_pkg::out_item_t            out_q;

  logic                           out_free, s1_move, s1_free, gen_fire, gen_last;
  logic [arfg_pkg::CNT_W-1:0]     last_cnt;
  logic [arfg_pkg::MEM_AW-1:0]    rd_addr;
  logic [arfg_pkg::CNT_W-1:0]     s1_off;
  logic [7:0]                     s1_byte;

  assign out_free = !out_valid_q || out_ch.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || s1_move;
  assign gen_fire = act_q && s1_free;
  assign last_cnt = (cmd_q.kind == arfg_pkg::PK_HEADER) ?
                    arfg_pkg::CNT_W'(arfg_pkg::HDR_BYTES - 1) :
                    arfg_pkg::CNT_W'(arfg_pkg::FRM_BYTES - 1);
  assign gen_last = cnt_q == last_cnt;

  assign cmd_ready_o = !act_q;
  assign idle_o      = !act_q && !cmd_valid_i;

  always_comb begin
    rd_addr = cmd_q.no_resp ? arfg_pkg::MEM_AW'(arfg_pkg::RECORD_BYTES) : '0;
    if (cnt_q >= arfg_pkg::CNT_W'(arfg_pkg::FIXED_BYTES)) begin
      rd_addr = rd_addr +
                arfg_pkg::MEM_AW'(cnt_q - arfg_pkg::CNT_W'(arfg_pkg::FIXED_BYTES));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_wr_i.we) begin
      mem_q[rec_wr_i.addr] <= rec_wr_i.data;
    end
    if (gen_fire) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign s1_off = s1_cnt_q - arfg_pkg::CNT_W'(arfg_pkg::FIXED_BYTES);

  always_comb begin
    unique case (s1_cnt_q)
      arfg_pkg::CNT_W'(0): s1_byte = (s1_cmd_q.kind == arfg_pkg::PK_HEADER) ?
                                     arfg_pkg::HDR_B0 : arfg_pkg::FRM_B0;
      arfg_pkg::CNT_W'(1): s1_byte = (s1_cmd_q.kind == arfg_pkg::PK_HEADER) ?
                                     arfg_pkg::HDR_B1 : arfg_pkg::FRM_B1;
      arfg_pkg::CNT_W'(2): s1_byte = s1_cmd_q.sid[7:0];
      arfg_pkg::CNT_W'(3): s1_byte = s1_cmd_q.sid[15:8];
      arfg_pkg::CNT_W'(4): s1_byte = (s1_cmd_q.kind == arfg_pkg::PK_HEADER) ?
                                     arfg_pkg::HDR_B4 : s1_cmd_q.fbyte;
      arfg_pkg::CNT_W'(5): s1_byte = (s1_cmd_q.kind == arfg_pkg::PK_HEADER) ?
                                     arfg_pkg::HDR_B5 : s1_cmd_q.pcnt;
      default: begin
        if (s1_cmd_q.kind == arfg_pkg::PK_HEADER) begin
          s1_byte = rd_q;
          // patch the leading flag bytes of the record
          if (s1_cmd_q.no_resp) begin
            if (s1_off == '0) begin
              s1_byte = arfg_pkg::NORESP_B0;
            end else if (s1_off < arfg_pkg::CNT_W'(3)) begin
              s1_byte = '0;
            end
          end else if (s1_off == '0) begin
            s1_byte = rd_q & arfg_pkg::BUSY_MASK;
          end
        end else begin
          s1_byte = arfg_pkg::voice_byte(s1_cmd_q.seq, s1_cmd_q.no_resp, 4'(s1_off));
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (!act_q && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (gen_fire) begin
      s1_cmd_q  <= cmd_q;
      s1_cnt_q  <= cnt_q;
      s1_last_q <= gen_last;
    end
    if (s1_move) begin
      out_q.out_byte       <= s1_byte;
      out_q.packet_kind    <= 2'(s1_cmd_q.kind);
      out_q.last_of_packet <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!act_q && cmd_valid_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (gen_fire) begin
        if (gen_last) begin
          act_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (gen_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

endmodule

// ----- sv/auto_reply_frame_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_reply_frame_generator_top
// Slow-data auto-reply sequencer: header and voice frame byte generator.
// ----------------------------------------------------------------------------
// A packet's first byte passes from its poll through the command queue and
// the emitter's command, read and output registers; bytes then follow one
// per cycle while the receiver is ready (47 for a header, 18 per frame),
// paced by the single byte emitter and its record store read port. The
// input takes one item per cycle while the two-entry command queue has
// room; the emitter takes a packet command only once the last one is done,
// and a full queue holds the input. A record load waits until the emitter
// has read out every queued packet. Reset is asynchronous, active low, and
// leaves the sequencer idle; the header record store holds no reset value.
// ----------------------------------------------------------------------------
module auto_reply_frame_generator_top #(
  parameter int VOICE_FRAMES = arfg_pkg::VOICE_FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arfg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  arfg_in_if.sink                         in_ch_i,
  arfg_out_if.source                      out_ch_o
);

  logic               push_valid, push_ready;
  arfg_pkg::pkt_cmd_t push_cmd;
  logic               pop_valid, pop_ready;
  arfg_pkg::pkt_cmd_t pop_cmd;
  arfg_pkg::rec_wr_t  rec_wr;
  logic               back_idle;

  arfg_front #(
    .VOICE_FRAMES (VOICE_FRAMES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .back_idle_i (back_idle),
    .cmd_ready_i (push_ready),
    .cmd_valid_o (push_valid),
    .cmd_o       (push_cmd),
    .rec_wr_o    (rec_wr)
  );

  arfg_cmd_fifo #(
    .DEPTH (arfg_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  arfg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_wr_i    (rec_wr),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .idle_o      (back_idle),
    .out_ch      (out_ch_o)
  );

endmodule

// ----- tb/auto_reply_frame_generator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_reply_frame_generator_top_test
// Self-checking bench for the auto-reply frame generator. A queue of items
// feeds a valid/ready driver; a clocked monitor runs a local copy of the reply
// sequencer on every accepted item and checks each emitted byte in order.
// Both sides idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module auto_reply_frame_generator_top_test;
  import arfg_pkg::*;

  localparam int N_FRAMES = VOICE_FRAMES_DEF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  arfg_in_if  in_ch ();
  arfg_out_if out_ch ();

  auto_reply_frame_generator_top #(
    .VOICE_FRAMES(N_FRAMES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch_i   (in_ch),
    .out_ch_o  (out_ch)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // stimulus and bookkeeping
  in_item_t  item_backlog[$];
  out_item_t reply_bytes_due[$];
  out_item_t byte_want;
  int        n_queued = 0;
  int        n_taken = 0;
  int        n_rcvd = 0;
  int        n_errors = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  logic      rx_hold = 1'b0;
  logic      in_taken = 1'b0;

  // local copy of the sequencer
  phase_e          seq_phase;
  reply_e          armed_reply;
  logic [16:0]     quiet_ticks;
  logic [4:0]      frame_no;
  logic [7:0]      pkt_cnt;
  logic [15:0]     sid_q;
  logic [7:0]      rec_mem[MEM_DEPTH];
  logic            gen_en;
  logic [15:0]     gen_wait;

  task automatic flag_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [7:0] text_byte(logic no_resp, int pos);
    logic [TEXT_W-1:0] txt;
    txt = no_resp ? TEXT_NORESP : TEXT_BUSY;
    return 8'(txt >> (8 * (TEXT_W / 8 - 1 - pos)));
  endfunction

  // Twelve voice data bytes of frame seq, byte 0 in the top bits.
  function automatic logic [95:0] slow_data_bytes(logic [4:0] seq, logic no_resp);
    logic [95:0] d;
    int          s;
    int          pos;
    s = int'(seq);
    d = (s == 0) ? SYNC_VOICE : FILL_VOICE;
    if (s >= 1 && s <= TEXT_SEQS) begin
      if (s % 2 == 1) begin
        pos       = 5 * ((s - 1) / 2);
        d[23:16]  = (MINI_HDR + 8'((s - 1) / 2)) ^ SCR_A;
        d[15:8]   = text_byte(no_resp, pos) ^ SCR_B;
        d[7:0]    = text_byte(no_resp, pos + 1) ^ SCR_C;
      end else begin
        pos       = 5 * (s / 2 - 1) + 2;
        d[23:16]  = text_byte(no_resp, pos) ^ SCR_A;
        d[15:8]   = text_byte(no_resp, pos + 1) ^ SCR_B;
        d[7:0]    = text_byte(no_resp, pos + 2) ^ SCR_C;
      end
    end
    return d;
  endfunction

  function automatic void queue_byte(logic [7:0] b, pkt_kind_e k, logic last);
    out_item_t e;
    e.out_byte       = b;
    e.packet_kind    = k;
    e.last_of_packet = last;
    reply_bytes_due.push_back(e);
  endfunction

  function automatic void queue_frame(logic [7:0] fbyte, logic [4:0] seq, pkt_kind_e k);
    logic [95:0] d;
    d = slow_data_bytes(seq, armed_reply == REPLY_NORESP);
    queue_byte(FRM_B0, k, 1'b0);
    queue_byte(FRM_B1, k, 1'b0);
    queue_byte(sid_q[7:0], k, 1'b0);
    queue_byte(sid_q[15:8], k, 1'b0);
    queue_byte(fbyte, k, 1'b0);
    queue_byte(pkt_cnt, k, 1'b0);
    for (int j = 0; j < VOICE_BYTES; j++) begin
      queue_byte(d[95 - 8 * j -: 8], k, j == VOICE_BYTES - 1);
    end
  endfunction

  task automatic advance_sequencer(in_item_t it);
    int         base;
    logic [7:0] b;
    logic [4:0] cur;
    // ticks pile up in the wait-check phase whatever the item is
    if (seq_phase == PH_WAIT_CHECK && it.time_tick && quiet_ticks != 17'h1ffff) begin
      quiet_ticks = quiet_ticks + 17'd1;
    end
    case (it.operation)
      OP_START: begin
        if (seq_phase == PH_IDLE) begin
          armed_reply = it.reply_kind ? REPLY_NORESP : REPLY_BUSY;
          seq_phase   = PH_WAIT_SET;
        end
      end
      OP_SKIP: begin
        seq_phase   = PH_IDLE;
        armed_reply = REPLY_NONE;
      end
      OP_LOAD: begin
        if (it.record_index < RECORD_BYTES) begin
          rec_mem[int'(it.record_select) * RECORD_BYTES + int'(it.record_index)] =
            it.record_byte;
        end
      end
      default: begin
        if (gen_en && armed_reply == REPLY_NONE) begin
          seq_phase = PH_IDLE;
        end else if (gen_en) begin
          case (seq_phase)
            PH_WAIT_SET: begin
              if (!it.squelch_open) begin
                quiet_ticks = '0;
                frame_no    = '0;
                seq_phase   = PH_WAIT_CHECK;
              end
            end
            PH_WAIT_CHECK: begin
              if (!it.squelch_open && quiet_ticks > {1'b0, gen_wait}) seq_phase = PH_HEADER;
            end
            PH_HEADER: begin
              sid_q   = it.session_id;
              pkt_cnt = '0;
              base    = (armed_reply == REPLY_BUSY) ? 0 : RECORD_BYTES;
              queue_byte(HDR_B0, PK_HEADER, 1'b0);
              queue_byte(HDR_B1, PK_HEADER, 1'b0);
              queue_byte(sid_q[7:0], PK_HEADER, 1'b0);
              queue_byte(sid_q[15:8], PK_HEADER, 1'b0);
              queue_byte(HDR_B4, PK_HEADER, 1'b0);
              queue_byte(HDR_B5, PK_HEADER, 1'b0);
              for (int i = 0; i < RECORD_BYTES; i++) begin
                b = rec_mem[base + i];
                // patch the record flags for the reply type
                if (armed_reply == REPLY_BUSY && i == 0) begin
                  b = b & BUSY_MASK;
                end else if (armed_reply == REPLY_NORESP && i < 3) begin
                  b = (i == 0) ? NORESP_B0 : 8'h00;
                end
                queue_byte(b, PK_HEADER, i == RECORD_BYTES - 1);
              end
              seq_phase = PH_HEADER_DONE;
            end
            PH_HEADER_DONE: seq_phase = PH_TEXT_SET;
            PH_TEXT_SET:    seq_phase = PH_VOICE_PREP;
            PH_VOICE_PREP:  seq_phase = PH_VOICE;
            PH_VOICE: begin
              pkt_cnt  = pkt_cnt + 8'd1;
              cur      = frame_no;
              frame_no = frame_no + 5'd1;
              if (int'(frame_no) >= N_FRAMES) seq_phase = PH_LAST_PREP;
              queue_frame({3'b000, cur}, cur, PK_VOICE);
            end
            PH_LAST_PREP: seq_phase = PH_LAST;
            PH_LAST: begin
              pkt_cnt   = pkt_cnt + 8'd1;
              seq_phase = PH_END;
              queue_frame({3'b000, frame_no} | LAST_FLAG,
                          (frame_no != '0) ? frame_no - 5'd1 : 5'd0, PK_LAST);
            end
            PH_END: begin
              seq_phase   = PH_IDLE;
              armed_reply = REPLY_NONE;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  endtask

  // driver: offer the next item at the falling edge
  always @(negedge clk_i) begin
    if (in_ch.valid && !in_taken) begin
      // hold the offered item until its transfer
    end else if (item_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_ch.data  <= item_backlog.pop_front();
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // monitor: check emitted bytes first, then predict from the accepted item
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_rcvd++;
      if (reply_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("byte %02h with nothing expected", out_ch.data.out_byte));
      end else begin
        byte_want = reply_bytes_due.pop_front();
        if (out_ch.data.out_byte !== byte_want.out_byte) begin
          flag_mismatch($sformatf("out_byte got %02h want %02h",
                                  out_ch.data.out_byte, byte_want.out_byte));
        end
        if (out_ch.data.packet_kind !== byte_want.packet_kind) begin
          flag_mismatch($sformatf("packet_kind got %0d want %0d",
                                  out_ch.data.packet_kind, byte_want.packet_kind));
        end
        if (out_ch.data.last_of_packet !== byte_want.last_of_packet) begin
          flag_mismatch($sformatf("last_of_packet got %0b want %0b",
                                  out_ch.data.last_of_packet, byte_want.last_of_packet));
        end
      end
    end
    in_taken <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      advance_sequencer(in_ch.data);
      n_taken++;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation     = 2'($urandom_range(3));
    it.time_tick     = 1'($urandom_range(1));
    it.squelch_open  = 1'($urandom_range(1));
    it.reply_kind    = 1'($urandom_range(1));
    it.session_id    = 16'($urandom);
    it.record_select = 1'($urandom_range(1));
    it.record_index  = 6'($urandom_range(63));
    it.record_byte   = 8'($urandom);
    return it;
  endfunction

  task automatic push_item(op_e op, logic tick, logic sq, logic kind, logic [15:0] sid);
    in_item_t it;
    it              = random_item();
    it.operation    = op;
    it.time_tick    = tick;
    it.squelch_open = sq;
    it.reply_kind   = kind;
    it.session_id   = sid;
    item_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic push_load(logic sel, logic [5:0] idx, logic [7:0] val);
    in_item_t it;
    it               = random_item();
    it.operation     = OP_LOAD;
    it.record_select = sel;
    it.record_index  = idx;
    it.record_byte   = val;
    item_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic push_noise();
    item_backlog.push_back(random_item());
    n_queued++;
  endtask

  // One armed reply with random content; some are cut short by a skip.
  task automatic queue_random_reply();
    int n_polls;
    int abort_at;
    n_polls  = $urandom_range(36, 24);
    abort_at = ($urandom_range(4) == 0) ? $urandom_range(n_polls - 1) : -1;
    push_item(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 16'($urandom));
    for (int k = 0; k < n_polls; k++) begin
      if (k == abort_at) begin
        push_item(OP_SKIP, 1'($urandom_range(1)), 1'b0, 1'b0, 16'($urandom));
        break;
      end
      if ($urandom_range(19) == 0) push_noise();
      push_item(OP_POLL, $urandom_range(99) < 60, $urandom_range(99) < 12,
                1'($urandom_range(1)), 16'($urandom));
    end
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      if ($urandom_range(9) == 0) push_noise();
      else queue_random_reply();
    end
  endtask

  // Wait until every item is taken and every byte is back, then let it settle.
  task automatic drain();
    while (n_taken != n_queued || reply_bytes_due.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENABLE) gen_en = val[0];
    else gen_wait = val;
  endtask

  task automatic set_pacing(int tx, int rx);
    @(posedge clk_i);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // long receiver stall once traffic is flowing
  initial begin
    while (n_rcvd < 600) @(negedge clk_i);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_ENABLE;
    cfg_data_i   = '0;
    seq_phase    = PH_IDLE;
    armed_reply  = REPLY_NONE;
    quiet_ticks  = '0;
    frame_no     = '0;
    pkt_cnt      = '0;
    sid_q        = '0;
    gen_en       = 1'b0;
    gen_wait     = WAIT_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill both header records; polls do nothing while disabled
    set_pacing(14, 55);
    for (int i = 0; i < MEM_DEPTH; i++) begin
      push_load(i >= RECORD_BYTES, 6'(i % RECORD_BYTES), (i == 0) ? 8'hff : 8'($urandom));
    end
    push_item(OP_START, 1'b1, 1'b0, 1'b0, 16'h5a5a);
    repeat (3) push_item(OP_POLL, 1'b1, 1'b0, 1'b0, 16'h5a5a);
    push_item(OP_SKIP, 1'b0, 1'b0, 1'b0, 16'h0000);
    drain();

    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_WAIT, 16'd0);
    set_pacing(14, 55);
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);    // nothing armed
    push_item(OP_START, 1'b1, 1'b0, 1'b0, 16'h1234);   // busy reply
    push_item(OP_START, 1'b0, 1'b0, 1'b1, 16'h0000);   // not idle: dropped
    push_item(OP_POLL, 1'b1, 1'b1, 1'b0, 16'h0000);    // squelch open holds
    push_item(OP_POLL, 1'b1, 1'b0, 1'b0, 16'h0000);
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);    // zero ticks is not enough
    push_item(OP_POLL, 1'b1, 1'b1, 1'b0, 16'h0000);    // tick counts while held
    push_load(1'b0, 6'd41, 8'h00);                     // index out of range
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'hffff);    // header
    push_load(1'b1, 6'd63, 8'hff);
    for (int k = 0; k < 18; k++) begin
      push_item(OP_POLL, 1'(k), 1'(k >> 1), 1'b0, 16'(k * 'h1111));
    end
    push_item(OP_START, 1'b0, 1'b0, 1'b1, 16'hffff);   // no-response reply
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'hffff);
    push_item(OP_POLL, 1'b1, 1'b0, 1'b0, 16'hffff);
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);
    repeat (5) push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);
    push_item(OP_SKIP, 1'b1, 1'b0, 1'b0, 16'h0000);    // abort mid-frames
    push_item(OP_POLL, 1'b0, 1'b0, 1'b0, 16'h0000);
    drain();

    // longest wait: the header is never reached
    write_reg(CFG_WAIT, 16'hffff);
    set_pacing(14, 55);
    push_item(OP_START, 1'b0, 1'b0, 1'b0, 16'h0f0f);
    repeat (6) push_item(OP_POLL, 1'b1, 1'b0, 1'b0, 16'h0f0f);
    push_item(OP_SKIP, 1'b1, 1'b0, 1'b0, 16'h0000);
    drain();

    write_reg(CFG_WAIT, 16'($urandom_range(6, 1)));
    set_pacing(14, 55);
    run_random(55);
    drain();

    write_reg(CFG_ENABLE, 16'd0);
    set_pacing(55, 14);
    repeat (20) push_noise();
    drain();

    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_WAIT, 16'd2);
    set_pacing(55, 14);
    run_random(55);
    drain();

    write_reg(CFG_WAIT, 16'd0);
    set_pacing(0, 0);
    run_random(55);
    drain();

    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
